// File: design/rsn_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ray-sphere normal shader.
// Depends on nothing; every other design file imports it.
package rsn_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS   = 16;
  localparam int UNIT_BITS   = 30;

  // Pipeline depths of the shared arithmetic units
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int UNIT_LAT    = 2 + SQRT_STAGES + DIV_STAGES + 1;

  // Register reset values
  localparam logic [31:0] CENTER_X_RST = 32'd0;
  localparam logic [31:0] CENTER_Y_RST = 32'd0;
  localparam logic [31:0] CENTER_Z_RST = 32'(-(64'sd1 <<< FRAC_BITS));
  localparam logic [30:0] RADIUS_RST   = 31'(64'd1 << (FRAC_BITS - 1));

  // Register indexes on the configuration port
  localparam logic [7:0] REG_CENTER_X = 8'd0;
  localparam logic [7:0] REG_CENTER_Y = 8'd1;
  localparam logic [7:0] REG_CENTER_Z = 8'd2;
  localparam logic [7:0] REG_RADIUS   = 8'd3;

  // Color scale 255.999 as a count of thousandths
  localparam logic [17:0] SHADE_MUL = 18'd255999;

  // Reciprocals: ceil(2^22 / 125) and ceil(2^28 / 625), exact over the operand ranges
  localparam logic [15:0] RECIP_125 = 16'd33555;
  localparam logic [18:0] RECIP_625 = 19'd429497;

  typedef logic [2:0][32:0] coord3_t;  // three signed 33-bit coordinates
  typedef logic [2:0][31:0] unit3_t;   // three signed Q1.30 components

  // Divisor that finishes a channel byte
  typedef enum logic [1:0] {
    DIV_2000  = 2'b00,
    DIV_4000  = 2'b01,
    DIV_20000 = 2'b10
  } div_sel_e;

  // Divide a scaled channel value by a small constant: strip the power of two,
  // then multiply by the reciprocal of 125 or 625
  function automatic logic [7:0] chan_byte(logic [22:0] q, div_sel_e sel);
    logic [36:0] p;
    logic [7:0]  res;
    unique case (sel)
      DIV_2000: begin
        p   = 37'(q[18:4]) * 37'(RECIP_125);
        res = p[29:22];
      end
      DIV_4000: begin
        p   = 37'(q[19:5]) * 37'(RECIP_125);
        res = p[29:22];
      end
      DIV_20000: begin
        p   = 37'(q[22:5]) * 37'(RECIP_625);
        res = p[35:28];
      end
      default: begin
        p   = 37'(q[18:4]) * 37'(RECIP_125);
        res = p[29:22];
      end
    endcase
    return res;
  endfunction

endpackage

// File: design/rsn_isqrt.sv
`timescale 1ns / 1ps
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on rsn_pkg for the stage count.
module rsn_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import rsn_pkg::*;

  logic [63:0] x_q    [SQRT_STAGES];
  logic [35:0] rem_q  [SQRT_STAGES];
  logic [31:0] root_q [SQRT_STAGES];

  logic [63:0] x_in    [SQRT_STAGES];
  logic [35:0] rem_in  [SQRT_STAGES];
  logic [31:0] root_in [SQRT_STAGES];
  logic [35:0] cur     [SQRT_STAGES];
  logic [35:0] trial   [SQRT_STAGES];
  logic [35:0] rem_d   [SQRT_STAGES];
  logic [31:0] root_d  [SQRT_STAGES];

  // One digit step per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    x_in[0]    = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      x_in[k]    = x_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
    for (int k = 0; k < SQRT_STAGES; k++) begin
      cur[k]   = {rem_in[k][33:0], x_in[k][2*(SQRT_STAGES-1-k)+1 -: 2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      if (cur[k] >= trial[k]) begin
        rem_d[k]  = cur[k] - trial[k];
        root_d[k] = {root_in[k][30:0], 1'b1};
      end else begin
        rem_d[k]  = cur[k];
        root_d[k] = {root_in[k][30:0], 1'b0};
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        x_q[k]    <= x_in[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// File: design/rsn_udiv.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^30 / den) for num <= den.
// Depends on rsn_pkg for the stage count.
module rsn_udiv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [30:0] quo_o
);
  import rsn_pkg::*;

  logic [31:0] r_q [DIV_STAGES];
  logic [30:0] q_q [DIV_STAGES];
  logic [31:0] d_q [DIV_STAGES];

  logic [32:0] cur   [DIV_STAGES];
  logic [31:0] den   [DIV_STAGES];
  logic [30:0] q_in  [DIV_STAGES];
  logic [31:0] r_d   [DIV_STAGES];
  logic [30:0] q_d   [DIV_STAGES];

  // One quotient bit per stage, top bit from the numerator itself
  always_comb begin
    cur[0]  = {1'b0, num_i};
    den[0]  = den_i;
    q_in[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      cur[k]  = {r_q[k-1], 1'b0};
      den[k]  = d_q[k-1];
      q_in[k] = q_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (cur[k] >= {1'b0, den[k]}) begin
        r_d[k] = 32'(cur[k] - {1'b0, den[k]});
        q_d[k] = {q_in[k][29:0], 1'b1};
      end else begin
        r_d[k] = cur[k][31:0];
        q_d[k] = {q_in[k][29:0], 1'b0};
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
        d_q[k] <= den[k];
      end
    end
  end

  assign quo_o = q_q[DIV_STAGES-1];

endmodule

// File: design/rsn_unit.sv
`timescale 1ns / 1ps
// Vector normalizer: length by integer square root, components to Q1.30.
// Depends on rsn_pkg, rsn_isqrt and rsn_udiv.
module rsn_unit (
  input  logic             clk_i,
  input  logic             en_i,
  input  rsn_pkg::coord3_t vec_i,
  output rsn_pkg::unit3_t  unit_o,
  output logic             nz_o
);
  import rsn_pkg::*;

  logic [2:0][31:0] mag_d;
  logic [2:0][31:0] mag0_q, mag1_q;
  logic [2:0]       neg0_q, neg1_q;
  logic [2:0][63:0] sq0_q;
  logic [63:0]      len2_q;
  logic [2:0][31:0] mag_line_q  [SQRT_STAGES];
  logic [2:0]       neg_line_q  [SQRT_STAGES + DIV_STAGES];
  logic             zero_line_q [DIV_STAGES];
  logic [31:0]      len_w;
  logic [2:0][30:0] quo_w;
  unit3_t           unit_d, unit_q;
  logic             nz_q;

  // Component magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][32] ? 32'(-vec_i[i]) : vec_i[i][31:0];
    end
  end

  // Square, then sum, then delay the magnitudes past the square root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag0_q[i] <= mag_d[i];
        neg0_q[i] <= vec_i[i][32];
        sq0_q[i]  <= mag_d[i] * mag_d[i];
      end
      mag1_q <= mag0_q;
      neg1_q <= neg0_q;
      len2_q <= sq0_q[0] + sq0_q[1] + sq0_q[2];
      mag_line_q[0]  <= mag1_q;
      neg_line_q[0]  <= neg1_q;
      zero_line_q[0] <= (len_w == 32'd0);
      for (int k = 1; k < SQRT_STAGES; k++) begin
        mag_line_q[k] <= mag_line_q[k-1];
      end
      for (int k = 1; k < SQRT_STAGES + DIV_STAGES; k++) begin
        neg_line_q[k] <= neg_line_q[k-1];
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        zero_line_q[k] <= zero_line_q[k-1];
      end
      unit_q <= unit_d;
      nz_q   <= !zero_line_q[DIV_STAGES-1];
    end
  end

  rsn_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (len2_q),
    .root_o (len_w)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    rsn_udiv u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (mag_line_q[SQRT_STAGES-1][i]),
      .den_i (len_w),
      .quo_o (quo_w[i])
    );
  end

  // Restore signs; a zero vector gives zeros
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_line_q[DIV_STAGES-1]) begin
        unit_d[i] = '0;
      end else if (neg_line_q[SQRT_STAGES + DIV_STAGES - 1][i]) begin
        unit_d[i] = 32'd0 - 32'(quo_w[i]);
      end else begin
        unit_d[i] = 32'(quo_w[i]);
      end
    end
  end

  assign unit_o = unit_q;
  assign nz_o   = nz_q;

endmodule

// File: design/ray_sphere_normal_shader.sv
`timescale 1ns / 1ps
// Ray-sphere normal shader, top level. Throughput: one request per cycle
// while the skid register is empty (s_axis_tready_o high).
// Depth is set by two vector normalizers (square root then divide, 66 stages
// each) and the discriminant square root (32 stages). A stalled output parks
// one result in a skid register and holds the whole pipeline.
// Reset clears valid bits and loads the default sphere (center (0,0,-1), r 0.5).
// Depends on rsn_pkg and rsn_unit, rsn_isqrt.
module ray_sphere_normal_shader (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // red, green, blue (8 bits each)
  output logic [23:0]  m_axis_tdata_o,
  // hit
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import rsn_pkg::*;

  localparam logic signed [64:0] TRUNC_BIAS = 65'sd1073741823;
  localparam logic [34:0]        ONE35      = 35'd1 << UNIT_BITS;

  // Configuration
  logic [31:0]      center_x_q, center_y_q, center_z_q;
  logic [30:0]      radius_q;
  logic [2:0][31:0] center;

  assign cfg_ready_o = 1'b1;
  assign center      = {center_z_q, center_y_q, center_x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      center_z_q <= CENTER_Z_RST;
      radius_q   <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_CENTER_Z: center_z_q <= cfg_data_i;
        REG_RADIUS:   radius_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable and output skid
  logic        en;
  logic        out_v_q, skid_v_q, out_free;
  logic [23:0] out_rgb_q, skid_rgb_q, tail_rgb;
  logic        out_hit_q, skid_hit_q;

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  // Valid bits
  logic                va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q, vj_q, vk_q;
  logic [UNIT_LAT-1:0]    v1_q, v3_q;
  logic [SQRT_STAGES-1:0] v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0;
      ve_q <= 1'b0; vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0;
      vi_q <= 1'b0; vj_q <= 1'b0; vk_q <= 1'b0;
      v1_q <= '0; v2_q <= '0; v3_q <= '0;
    end else if (en) begin
      va_q <= s_axis_tvalid_i;
      v1_q <= {v1_q[UNIT_LAT-2:0], va_q};
      vb_q <= v1_q[UNIT_LAT-1];
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      v2_q <= {v2_q[SQRT_STAGES-2:0], vf_q};
      vg_q <= v2_q[SQRT_STAGES-1];
      vh_q <= vg_q;
      vi_q <= vh_q;
      v3_q <= {v3_q[UNIT_LAT-2:0], vi_q};
      vj_q <= v3_q[UNIT_LAT-1];
      vk_q <= vj_q;
    end
  end

  // Stage A: capture direction, offset origin from the center
  coord3_t da_q, oca_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        da_q[i]  <= 33'($signed(s_axis_tdata_i[32*(i+3) +: 32]));
        oca_q[i] <= 33'($signed(s_axis_tdata_i[32*i +: 32])) - 33'($signed(center[i]));
      end
    end
  end

  // Unit direction
  unit3_t u1_w;
  logic   nz1_w;

  rsn_unit u_unit_dir (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (da_q),
    .unit_o (u1_w),
    .nz_o   (nz1_w)
  );

  coord3_t oc_line_q [UNIT_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      oc_line_q[0] <= oca_q;
      for (int k = 1; k < UNIT_LAT; k++) begin
        oc_line_q[k] <= oc_line_q[k-1];
      end
    end
  end

  // Stage B: projection products and squared offsets
  coord3_t          ocb_q;
  unit3_t           ub_q;
  logic             nzb_q;
  logic [2:0][64:0] pb_q;
  logic [2:0][65:0] o2b_q;
  logic [2:0][32:0] ocm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ocm[i] = oc_line_q[UNIT_LAT-1][i][32] ? 33'(-oc_line_q[UNIT_LAT-1][i])
                                           : oc_line_q[UNIT_LAT-1][i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pb_q[i]  <= $signed(oc_line_q[UNIT_LAT-1][i]) * $signed(u1_w[i]);
        o2b_q[i] <= ocm[i] * ocm[i];
      end
      ocb_q <= oc_line_q[UNIT_LAT-1];
      ub_q  <= u1_w;
      nzb_q <= nz1_w;
    end
  end

  // Stage C: half-b term with truncation toward zero, and |oc|^2
  logic signed [64:0] tb [3];
  logic signed [35:0] h_d, hc_q;
  logic [67:0]        occc_q;
  coord3_t            occ_oc_q;
  unit3_t             uc_q;
  logic               nzc_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tb[i] = ($signed(pb_q[i]) + (pb_q[i][64] ? TRUNC_BIAS : 65'sd0)) >>> UNIT_BITS;
    end
    h_d = 36'(tb[0]) + 36'(tb[1]) + 36'(tb[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hc_q     <= h_d;
      occc_q   <= 68'(o2b_q[0]) + 68'(o2b_q[1]) + 68'(o2b_q[2]);
      occ_oc_q <= ocb_q;
      uc_q     <= ub_q;
      nzc_q    <= nzb_q;
    end
  end

  // Stage D: h^2 and r^2
  logic [34:0]        hm;
  logic [69:0]        hhd_q;
  logic [61:0]        rrd_q;
  logic [67:0]        occd_q;
  logic signed [35:0] hd_q;
  coord3_t            ocd_q;
  unit3_t             ud_q;
  logic               nzd_q;

  assign hm = hc_q[35] ? 35'(-hc_q) : hc_q[34:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hhd_q  <= hm * hm;
      rrd_q  <= radius_q * radius_q;
      occd_q <= occc_q;
      hd_q   <= hc_q;
      ocd_q  <= occ_oc_q;
      ud_q   <= uc_q;
      nzd_q  <= nzc_q;
    end
  end

  // Stage E: h^2 + r^2
  logic [70:0]        lhse_q;
  logic [67:0]        occe_q;
  logic signed [35:0] he_q;
  coord3_t            oce_q;
  unit3_t             ue_q;
  logic               nze_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lhse_q <= 71'(hhd_q) + 71'(rrd_q);
      occe_q <= occd_q;
      he_q   <= hd_q;
      oce_q  <= ocd_q;
      ue_q   <= ud_q;
      nze_q  <= nzd_q;
    end
  end

  // Stage F: discriminant, saturated to 64 bits
  logic [70:0] diff;
  logic [63:0] discf_q;
  logic        okf_q;
  logic signed [35:0] hf_q;
  coord3_t     ocf_q;
  unit3_t      uf_q;

  assign diff = lhse_q - 71'(occe_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      discf_q <= (|diff[70:64]) ? '1 : diff[63:0];
      okf_q   <= nze_q && (lhse_q >= 71'(occe_q));
      hf_q    <= he_q;
      ocf_q   <= oce_q;
      uf_q    <= ue_q;
    end
  end

  // Square root of the discriminant, side data alongside
  typedef struct packed {
    logic               ok;
    logic signed [35:0] h;
    coord3_t            oc;
    unit3_t             u;
  } side2_t;

  logic [31:0] s_w;
  side2_t      side2_q [SQRT_STAGES];

  rsn_isqrt u_sqrt_disc (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (discf_q),
    .root_o (s_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q[0] <= '{ok: okf_q, h: hf_q, oc: ocf_q, u: uf_q};
      for (int k = 1; k < SQRT_STAGES; k++) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  // Stage G: near root and hit test
  side2_t             s2;
  logic signed [37:0] t_d;
  logic [35:0]        tg_q;
  logic               hitg_q;
  coord3_t            ocg_q;
  unit3_t             ug_q;

  assign s2  = side2_q[SQRT_STAGES-1];
  assign t_d = -38'(s2.h) - $signed({6'b0, s_w});

  always_ff @(posedge clk_i) begin
    if (en) begin
      tg_q   <= t_d[35:0];
      hitg_q <= s2.ok && (t_d > 38'sd0);
      ocg_q  <= s2.oc;
      ug_q   <= s2.u;
    end
  end

  // Stage H: distance along each unit component
  logic [2:0][30:0] umag;
  logic [2:0][66:0] prod_h;
  logic [2:0][36:0] steph_q;
  logic [2:0]       usgh_q;
  coord3_t          och_q;
  logic             hith_q;
  logic [31:0]      uyh_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      umag[i]   = ug_q[i][31] ? 31'(-ug_q[i]) : ug_q[i][30:0];
      prod_h[i] = tg_q * umag[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        steph_q[i] <= prod_h[i][66:UNIT_BITS];
        usgh_q[i]  <= ug_q[i][31];
      end
      och_q  <= ocg_q;
      hith_q <= hitg_q;
      uyh_q  <= ug_q[1];
    end
  end

  // Stage I: surface normal, clamped to +-2^31
  logic signed [38:0] nv [3];
  coord3_t            nvi_q;
  logic               hiti_q;
  logic [31:0]        uyi_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = usgh_q[i] ? 39'($signed(och_q[i])) - $signed({2'b0, steph_q[i]})
                        : 39'($signed(och_q[i])) + $signed({2'b0, steph_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        priority if (nv[i] > 39'sd2147483648) begin
          nvi_q[i] <= 33'sd2147483648;
        end else if (nv[i] < -39'sd2147483648) begin
          nvi_q[i] <= -33'sd2147483648;
        end else begin
          nvi_q[i] <= 33'(nv[i]);
        end
      end
      hiti_q <= hith_q;
      uyi_q  <= uyh_q;
    end
  end

  // Unit normal, hit flag and sky factor alongside
  typedef struct packed {
    logic        hit;
    logic [31:0] uy;
  } side3_t;

  unit3_t n_w;
  side3_t side3_q [UNIT_LAT];

  rsn_unit u_unit_nrm (
    .clk_i  (clk_i),
    .en_i   (en),
    .vec_i  (nvi_q),
    .unit_o (n_w),
    .nz_o   ()
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q[0] <= '{hit: hiti_q, uy: uyi_q};
      for (int k = 1; k < UNIT_LAT; k++) begin
        side3_q[k] <= side3_q[k-1];
      end
    end
  end

  // Stage J: channel numerators and divisor choice
  side3_t           s3;
  logic [31:0]      w;
  logic [2:0][34:0] a_d, aj_q;
  div_sel_e         sel_d [3];
  div_sel_e         selj_q [3];
  logic             hitj_q;

  assign s3 = side3_q[UNIT_LAT-1];
  assign w  = s3.uy + 32'(ONE35);

  always_comb begin
    if (s3.hit) begin
      for (int i = 0; i < 3; i++) begin
        a_d[i]   = 35'($signed(n_w[i])) + ONE35;
        sel_d[i] = DIV_2000;
      end
    end else begin
      a_d[0]   = (35'd1 << 32) - 35'(w);
      sel_d[0] = DIV_4000;
      a_d[1]   = (35'd5 << 32) - 35'd3 * 35'(w);
      sel_d[1] = DIV_20000;
      a_d[2]   = 35'd1 << 31;
      sel_d[2] = DIV_2000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      aj_q   <= a_d;
      selj_q <= sel_d;
      hitj_q <= s3.hit;
    end
  end

  // Stage K: scale by 255.999 in thousandths
  logic [2:0][52:0] prod_k;
  logic [2:0][22:0] qk_q;
  div_sel_e         selk_q [3];
  logic             hitk_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_k[i] = 53'(aj_q[i]) * 53'(SHADE_MUL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qk_q[i] <= prod_k[i][UNIT_BITS +: 23];
      end
      selk_q <= selj_q;
      hitk_q <= hitj_q;
    end
  end

  // Finish the channel bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tail_rgb[8*i +: 8] = chan_byte(qk_q[i], selk_q[i]);
    end
  end

  // Output register with skid: drain the skid first, park when stalled
  assign out_free = !out_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= en && vk_q;
      end
    end else if (en && vk_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_rgb_q <= skid_rgb_q;
        out_hit_q <= skid_hit_q;
      end else begin
        out_rgb_q <= tail_rgb;
        out_hit_q <= hitk_q;
      end
    end else if (en && vk_q) begin
      skid_rgb_q <= tail_rgb;
      skid_hit_q <= hitk_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_rgb_q;
  assign m_axis_tuser_o  = out_hit_q;

endmodule
